// ----- rtl/core/sjf_pkg.sv -----
// shared types and field widths for the shortest-job-first scheduler
`timescale 1ns / 1ps
package sjf_pkg;

  // width of the input burst field and of the output fields
  localparam int unsigned ProcNumW  = 7;
  localparam int unsigned JobBurstW = 16;
  localparam int unsigned TimeW     = 22;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 112;

  // operation a cell of the sorted chain performs
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } sjf_op_e;

endpackage

// ----- rtl/core/sjf_cell.sv -----
// one cell of the sorted chain: holds one job, inserts or shifts toward cell 0
`timescale 1ns / 1ps
module sjf_cell
  import sjf_pkg::*;
#(
  parameter int unsigned BW = 16,
  parameter int unsigned NW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sjf_op_e          op_i,
  input  logic [NW+BW:0]   new_i,      // {valid, number, burst}
  input  logic [NW+BW:0]   left_i,
  input  logic             left_gt_i,
  input  logic [NW+BW:0]   right_i,
  output logic             gt_o,
  output logic [NW+BW:0]   entry_o
);

  logic            valid_q, valid_d;
  logic [NW+BW-1:0] data_q, data_d;

  // slot is empty or holds a strictly longer job, so the new job goes at or before it
  assign gt_o    = !valid_q || (data_q[BW-1:0] > new_i[BW-1:0]);
  assign entry_o = {valid_q, data_q};

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (op_i)
      OP_INSERT: begin
        if (gt_o) begin
          if (left_gt_i) begin
            valid_d = left_i[NW+BW];
            data_d  = left_i[NW+BW-1:0];
          end else begin
            valid_d = new_i[NW+BW];
            data_d  = new_i[NW+BW-1:0];
          end
        end
      end
      OP_SHIFT: begin
        valid_d = right_i[NW+BW];
        data_d  = right_i[NW+BW-1:0];
      end
      default: begin
        valid_d = valid_q;
        data_d  = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- rtl/core/sjf_divider.sv -----
// restoring divider, one quotient bit per cycle, two dividends over one divisor
`timescale 1ns / 1ps
module sjf_divider #(
  parameter int unsigned DVD_W = 28,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_a_i,
  input  logic [DVD_W-1:0] dvd_b_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_a_o,
  output logic [DVD_W-1:0] quo_b_o
);

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_a_q, rem_b_q;
  logic [DVD_W-1:0] quo_a_q, quo_b_q;
  logic [DVS_W:0]   trial_a, trial_b;
  logic             fit_a, fit_b;

  assign trial_a = {rem_a_q, quo_a_q[DVD_W-1]};
  assign trial_b = {rem_b_q, quo_b_q[DVD_W-1]};
  assign fit_a   = trial_a >= {1'b0, dvs_q};
  assign fit_b   = trial_b >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q   <= dvs_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
      quo_a_q <= dvd_a_i;
      quo_b_q <= dvd_b_i;
    end else if (busy_q) begin
      rem_a_q <= fit_a ? DVS_W'(trial_a - {1'b0, dvs_q}) : trial_a[DVS_W-1:0];
      rem_b_q <= fit_b ? DVS_W'(trial_b - {1'b0, dvs_q}) : trial_b[DVS_W-1:0];
      quo_a_q <= {quo_a_q[DVD_W-2:0], fit_a};
      quo_b_q <= {quo_b_q[DVD_W-2:0], fit_b};
    end
  end

  assign quo_a_o = quo_a_q;
  assign quo_b_o = quo_b_q;

endmodule

// ----- rtl/core/shortest_job_first_schedule.sv -----
// shortest-job-first scheduler: sorted cell chain, totals pass, divider, emission
// an input burst is taken every cycle while a run loads and enters the sorted chain as it transfers;
// after the last job of a run the chain is rotated once around to form the totals, the bit-serial
// divider then forms both means, then one result goes out per cycle while the receiver is ready
// no input is taken from the end of a run until its last result transfers
// reset clears the chain's valid bits, the job count and the control state
`timescale 1ns / 1ps
module shortest_job_first_schedule
  import sjf_pkg::*;
#(
  parameter int unsigned MAX_JOBS   = 64,
  parameter int unsigned BURST_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [15:0] burst
  input  logic                s_axis_tlast,   // final_job
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [6:0] process_number, [22:7] job_burst, [44:23] wait_res, [66:45] turnaround,
  // [88:67] mean_wait, [110:89] mean_turnaround, [111] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast    // run_end
);

  localparam int unsigned BW    = BURST_BITS;
  localparam int unsigned CntW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned EntW  = 1 + CntW + BW;
  localparam int unsigned AccW  = BW + CntW;
  localparam int unsigned TotW  = AccW + CntW;
  localparam int unsigned RotW  = $clog2(MAX_JOBS);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [RotW-1:0] rot_q;
  logic            div_start_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic [TotW-1:0] tot_w_q, tot_t_q;

  logic [EntW-1:0] ent [MAX_JOBS];
  logic            gt  [MAX_JOBS];
  logic [EntW-1:0] new_ent;
  logic [EntW-1:0] tail_in;
  sjf_op_e         op;
  logic            in_xfer, out_xfer, run_done;
  logic            div_done;
  logic [TotW-1:0] mean_w, mean_t;
  logic [BW-1:0]   head_burst;
  logic            head_valid;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign run_done = s_axis_tlast || (count_q == CntW'(MAX_JOBS - 1));

  assign new_ent    = {1'b1, CntW'(count_q + 1'b1), BW'(s_axis_tdata)};
  assign head_burst = ent[0][BW-1:0];
  assign head_valid = ent[0][EntW-1];

  // rotate during the totals pass, drain with empty slots during emission
  assign tail_in = (state_q == ST_SUM) ? ent[0] : '0;

  always_comb begin
    op = OP_HOLD;
    if (in_xfer) begin
      op = OP_INSERT;
    end else if (state_q == ST_SUM || out_xfer) begin
      op = OP_SHIFT;
    end
  end

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic [EntW-1:0] left_e, right_e;
    logic            left_gt;
    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = ent[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_last
      assign right_e = tail_in;
    end else begin : g_inner
      assign right_e = ent[i+1];
    end
    sjf_cell #(
      .BW (BW),
      .NW (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .new_i     (new_ent),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .gt_o      (gt[i]),
      .entry_o   (ent[i])
    );
  end

  sjf_divider #(
    .DVD_W (TotW),
    .DVS_W (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .dvd_a_i (tot_w_q),
    .dvd_b_i (tot_t_q),
    .dvs_i   (count_q),
    .done_o  (div_done),
    .quo_a_o (mean_w),
    .quo_b_o (mean_t)
  );

  assign acc_d = acc_q + AccW'(head_burst);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      rot_q       <= '0;
      div_start_q <= 1'b0;
      acc_q       <= '0;
      tot_w_q     <= '0;
      tot_t_q     <= '0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          acc_q   <= '0;
          tot_w_q <= '0;
          tot_t_q <= '0;
          rot_q   <= '0;
          if (in_xfer) begin
            count_q <= count_q + 1'b1;
            if (run_done) begin
              state_q <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          rot_q <= rot_q + 1'b1;
          if (head_valid) begin
            tot_w_q <= tot_w_q + TotW'(acc_q);
            tot_t_q <= tot_t_q + TotW'(acc_d);
            acc_q   <= acc_d;
          end
          if (rot_q == RotW'(MAX_JOBS - 1)) begin
            state_q     <= ST_DIV;
            div_start_q <= 1'b1;
          end
        end
        ST_DIV: begin
          acc_q <= '0;
          if (div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            acc_q <= acc_d;
            if (m_axis_tlast) begin
              state_q <= ST_LOAD;
              count_q <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  logic [AccW-1:0] turn;
  assign turn = acc_d;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tlast  = !ent[1][EntW-1];
  assign m_axis_tdata  = {1'b0,
                          TimeW'(mean_t),
                          TimeW'(mean_w),
                          TimeW'(turn),
                          TimeW'(acc_q),
                          JobBurstW'(head_burst),
                          ProcNumW'(ent[0][BW +: CntW])};

endmodule

// ----- rtl/core/sjf_checker.sv -----
// port-level checks on the scheduler, bound to the top level
`timescale 1ns / 1ps
module sjf_checker
  import sjf_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // loading and emission never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results are pending");

  // turnaround is waiting time plus own burst
  a_turn_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[66:45] == TimeW'(m_axis_tdata[44:23] + TimeW'(m_axis_tdata[22:7])))
    else $error("turnaround differs from wait plus burst");

  // next job waits exactly as long as the previous one took to finish
  a_wait_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[44:23] == $past(m_axis_tdata[66:45]))
    else $error("waiting time does not follow previous turnaround");

  // averages hold across a run
  a_mean_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid) |-> $stable(m_axis_tdata[110:67]))
    else $error("averages changed within a run");

endmodule

bind shortest_job_first_schedule sjf_checker u_sjf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/testbench.sv -----
// self-checking testbench for the shortest-job-first scheduler, with stream stimulus and scoreboard
`timescale 1ns / 1ps
module testbench;
  import sjf_pkg::*;

  localparam int unsigned MaxJobs     = 64;
  localparam int unsigned BurstBits   = 16;
  localparam int unsigned GapPct      = 26;
  localparam int unsigned StallCycles = 400;
  localparam int unsigned TailCycles  = 200;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned RandomJobs  = 430;
  localparam int unsigned QuietJobs   = 100;
  localparam int unsigned PrintCap    = 100;

  typedef struct packed {
    logic [ProcNumW-1:0]  number;
    logic [JobBurstW-1:0] burst;
  } job_t;

  typedef struct packed {
    logic [ProcNumW-1:0]  number;
    logic [JobBurstW-1:0] burst;
    logic [TimeW-1:0]     queued_for;
    logic [TimeW-1:0]     turnaround;
    logic [TimeW-1:0]     mean_wait;
    logic [TimeW-1:0]     mean_turn;
    logic                 run_end;
  } slot_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // jobs loaded into the current run, and schedule entries still to come out
  job_t  loaded_jobs[$];
  slot_t slot_q[$];
  slot_t want;

  int errors       = 0;
  int printed      = 0;
  int runs_done    = 0;
  int full_runs    = 0;
  int jobs_sent    = 0;
  int slots_seen   = 0;
  bit gaps_on      = 1'b1;
  bit stall_req    = 1'b0;

  shortest_job_first_schedule #(
    .MAX_JOBS  (MaxJobs),
    .BURST_BITS(BurstBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    errors++;
    if (printed < PrintCap) begin
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, exp_val);
      printed++;
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // order the loaded run by burst (stable) and queue one schedule entry per job
  function automatic void schedule_run();
    job_t        order[$];
    job_t        key;
    slot_t       s;
    int          i;
    int          j;
    int          n;
    logic [63:0] acc;
    logic [63:0] tot_w;
    logic [63:0] tot_t;
    order = loaded_jobs;
    n = order.size();
    for (i = 1; i < n; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && order[j-1].burst > key.burst) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    acc = '0;
    tot_w = '0;
    tot_t = '0;
    for (i = 0; i < n; i++) begin
      tot_w += acc;
      acc += order[i].burst;
      tot_t += acc;
    end
    acc = '0;
    for (i = 0; i < n; i++) begin
      s.number     = order[i].number;
      s.burst      = order[i].burst;
      s.queued_for = acc[TimeW-1:0];
      s.turnaround = TimeW'(acc + order[i].burst);
      s.mean_wait  = TimeW'(tot_w / n);
      s.mean_turn  = TimeW'(tot_t / n);
      s.run_end    = (i == n - 1);
      slot_q.push_back(s);
      acc += order[i].burst;
    end
  endfunction

  function automatic void predict_job(input logic [InDataW-1:0] b, input logic is_last);
    job_t jb;
    jb.number = ProcNumW'(loaded_jobs.size() + 1);
    jb.burst  = b[BurstBits-1:0];
    loaded_jobs.push_back(jb);
    if (is_last || loaded_jobs.size() == MaxJobs) begin
      if (!is_last) full_runs++;
      schedule_run();
      loaded_jobs.delete();
      runs_done++;
    end
  endfunction

  // called just after a rising edge; returns at the edge where the transfer happened
  task automatic send_job(input logic [InDataW-1:0] b, input logic is_last);
    while (gaps_on && $urandom_range(99) < GapPct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    jobs_sent++;
    predict_job(b, is_last);
  endtask

  task automatic wait_for_schedules();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (slot_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // receiver: random idling, or a long hold-off when asked
  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        stall_req = 1'b0;
      end else if (gaps_on) begin
        m_axis_tready <= ($urandom_range(99) >= GapPct);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      slots_seen++;
      if (slot_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected, process_number",
                        m_axis_tdata[6:0], 0);
      end else begin
        want = slot_q.pop_front();
        check_field("process_number", m_axis_tdata[6:0], want.number);
        check_field("job_burst", m_axis_tdata[22:7], want.burst);
        check_field("wait_res", m_axis_tdata[44:23], want.queued_for);
        check_field("turnaround", m_axis_tdata[66:45], want.turnaround);
        check_field("mean_wait", m_axis_tdata[88:67], want.mean_wait);
        check_field("mean_turnaround", m_axis_tdata[110:89], want.mean_turn);
        check_field("tdata padding", m_axis_tdata[111], 0);
        check_field("run_end", m_axis_tlast, want.run_end);
      end
    end
  end

  task automatic test_single_jobs();
    send_job(16'h0000, 1'b1);
    send_job(16'hFFFF, 1'b1);
    wait_for_schedules();
  endtask

  task automatic test_field_extremes();
    send_job(16'hFFFF, 1'b0);
    send_job(16'h0000, 1'b0);
    send_job(16'hAAAA, 1'b0);
    send_job(16'h5555, 1'b0);
    send_job(16'h8000, 1'b0);
    send_job(16'h0001, 1'b1);
    wait_for_schedules();
  endtask

  // ties must come out in arrival order
  task automatic test_equal_bursts();
    send_job(16'd9, 1'b0);
    send_job(16'd9, 1'b0);
    send_job(16'd3, 1'b0);
    send_job(16'd9, 1'b0);
    send_job(16'd3, 1'b0);
    send_job(16'd9, 1'b1);
    wait_for_schedules();
  endtask

  task automatic test_sorted_inputs();
    send_job(16'd1, 1'b0);
    send_job(16'd2, 1'b0);
    send_job(16'd3, 1'b1);
    send_job(16'd300, 1'b0);
    send_job(16'd200, 1'b0);
    send_job(16'd100, 1'b1);
    wait_for_schedules();
  endtask

  // full store of maximum bursts while the receiver holds off, so the input stalls
  task automatic test_backpressure();
    int k;
    stall_req = 1'b1;
    for (k = 0; k < MaxJobs; k++) send_job(16'hFFFF, 1'b0);
    for (k = 1; k <= 10; k++) send_job(InDataW'($urandom), k == 10);
    wait_for_schedules();
  endtask

  task automatic test_random_runs();
    int               len;
    int               k;
    int               pick;
    int               sent;
    logic             is_last;
    logic [InDataW-1:0] b;
    logic [InDataW-1:0] prev;
    sent = 0;
    prev = '0;
    gaps_on = 1'b0;
    while (sent < RandomJobs) begin
      if (sent >= QuietJobs) gaps_on = 1'b1;
      pick = $urandom_range(99);
      if (pick < 80) len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(40, 9);
      else len = MaxJobs;
      for (k = 1; k <= len; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) b = InDataW'($urandom);
        else if (pick < 70) b = InDataW'($urandom_range(15));
        else if (pick < 85) b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else b = prev;
        // a full store ends the run whether or not tlast is set
        if (k < len) is_last = 1'b0;
        else if (len == MaxJobs) is_last = 1'($urandom_range(1));
        else is_last = 1'b1;
        send_job(b, is_last);
        prev = b;
        sent++;
      end
    end
    wait_for_schedules();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_jobs();
    test_field_extremes();
    test_equal_bursts();
    test_sorted_inputs();
    test_backpressure();
    test_random_runs();
    if (slot_q.size() != 0) report_mismatch("schedule entries never delivered", slot_q.size(), 0);
    $display("covered %0d runs (%0d closed by a full store), %0d jobs in, %0d entries checked",
             runs_done, full_runs, jobs_sent, slots_seen);
    $display("ties, extreme bursts, a %0d-cycle receiver hold-off and an idle-free stretch included",
             StallCycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
